// ===== hdl/uaa_pkg.sv =====
// ============================================================================
// uaa_pkg
// Shared types for the node address assigner: state, status codes and the
// command group sent from the scan controller to the id table.
// ============================================================================
package uaa_pkg;

    // Result status codes.
    typedef enum logic [1:0] {
        STAT_KNOWN   = 2'd0,
        STAT_NEW     = 2'd1,
        STAT_FULL    = 2'd2,
        STAT_CLEARED = 2'd3
    } status_t;

    // Scan controller states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_RESP
    } state_t;

    // Commands from the controller to the id table.
    typedef struct packed {
        logic rd_en;
        logic wr_en;
        logic clr;
    } tbl_cmd_t;

endpackage

// ===== hdl/uaa_id_table.sv =====
// ============================================================================
// uaa_id_table
// Slot table: a synchronous id memory with a registered read port and a row
// of used flags in flip-flops that a clear drops all at once.
// ============================================================================
module uaa_id_table #(
    parameter int TABLE_SLOTS = 256,
    parameter int AW          = 8
) (
    input  logic               clk,
    input  logic               rst_n,
    input  uaa_pkg::tbl_cmd_t  cmd,
    input  logic [AW-1:0]      rd_addr,
    input  logic [AW-1:0]      wr_addr,
    input  logic [31:0]        wr_data,
    output logic [31:0]        rd_data,
    output logic               rd_used
);
    import uaa_pkg::*;

    logic [31:0]            mem [TABLE_SLOTS];
    logic [TABLE_SLOTS-1:0] used_reg;
    logic [31:0]            rd_data_reg;
    logic                   rd_used_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (cmd.rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
            rd_used_reg <= used_reg[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg <= '0;
        end
        else if (cmd.clr)
        begin
            used_reg <= '0;
        end
        else if (cmd.wr_en)
        begin
            used_reg[wr_addr] <= 1'b1;
        end
    end

    assign rd_data = rd_data_reg;
    assign rd_used = rd_used_reg;

endmodule

// ===== hdl/uaa_scan_ctrl.sv =====
// ============================================================================
// uaa_scan_ctrl
// Request sequencer: walks the slot table one read per cycle, tracks the
// lowest free slot, claims it on a miss and holds the result beat.
// ============================================================================
module uaa_scan_ctrl #(
    parameter int TABLE_SLOTS = 256,
    parameter int AW          = 8
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic               s_func,
    input  logic [31:0]        s_id,
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [1:0]         m_status,
    output logic [7:0]         m_addr,
    output logic [31:0]        m_id,
    output uaa_pkg::tbl_cmd_t  cmd,
    output logic [AW-1:0]      rd_addr,
    output logic [AW-1:0]      wr_addr,
    output logic [31:0]        wr_data,
    input  logic [31:0]        rd_data,
    input  logic               rd_used
);
    import uaa_pkg::*;

    localparam logic [AW-1:0] LAST_SLOT = AW'(TABLE_SLOTS - 1);

    state_t        state_reg, state_next;
    logic [31:0]   id_reg;
    logic [AW-1:0] scan_addr_reg;
    logic          free_found_reg;
    logic [AW-1:0] free_addr_reg;
    status_t       res_status_reg;
    logic [7:0]    res_addr_reg;
    logic          m_tvalid_reg;
    status_t       out_status_reg;
    logic [7:0]    out_addr_reg;
    logic [31:0]   out_id_reg;

    logic hit;
    logic at_last;
    logic load_out;

    // Data for scan_addr_reg is on the table output during ST_SCAN.
    assign hit     = rd_used && (rd_data == id_reg);
    assign at_last = (scan_addr_reg == LAST_SLOT);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = s_func ? ST_RESP : ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (hit || at_last)
                begin
                    state_next = ST_RESP;
                end
            end
            ST_RESP:
            begin
                if (load_out)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        s_tready  = 1'b0;
        cmd       = '0;
        rd_addr   = scan_addr_reg + 1'b1;
        load_out  = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    if (s_func)
                    begin
                        cmd.clr = 1'b1;
                    end
                    else
                    begin
                        cmd.rd_en = 1'b1;
                        rd_addr   = AW'(1);
                    end
                end
            end
            ST_SCAN:
            begin
                if (!hit && !at_last)
                begin
                    cmd.rd_en = 1'b1;
                end
                if (!hit && at_last && free_found_reg)
                begin
                    cmd.wr_en = 1'b1;
                end
            end
            ST_RESP:
            begin
                load_out = !m_tvalid_reg || m_tready;
            end
            default:
            begin
                s_tready = 1'b0;
            end
        endcase
    end

    assign wr_addr = free_addr_reg;
    assign wr_data = id_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            free_found_reg <= 1'b0;
            m_tvalid_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_IDLE && s_tvalid)
            begin
                free_found_reg <= 1'b0;
            end
            else if (state_reg == ST_SCAN && !rd_used && !free_found_reg && !at_last)
            begin
                free_found_reg <= 1'b1;
            end
            if (load_out)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && s_tvalid)
        begin
            id_reg         <= s_id;
            scan_addr_reg  <= AW'(1);
            res_status_reg <= STAT_CLEARED;
            res_addr_reg   <= 8'd0;
        end
        else if (state_reg == ST_SCAN)
        begin
            scan_addr_reg <= scan_addr_reg + 1'b1;
            if (!rd_used && !free_found_reg && !at_last)
            begin
                free_addr_reg <= scan_addr_reg;
            end
            if (hit)
            begin
                res_status_reg <= STAT_KNOWN;
                res_addr_reg   <= 8'(scan_addr_reg);
            end
            else if (at_last)
            begin
                res_status_reg <= free_found_reg ? STAT_NEW : STAT_FULL;
                res_addr_reg   <= free_found_reg ? 8'(free_addr_reg) : 8'd0;
            end
        end
        if (load_out)
        begin
            out_status_reg <= res_status_reg;
            out_addr_reg   <= res_addr_reg;
            out_id_reg     <= id_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_status = out_status_reg;
    assign m_addr   = out_addr_reg;
    assign m_id     = out_id_reg;

    // A slot is only claimed at the end of a full walk that saw a free slot.
    a_claim_after_walk: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.wr_en |-> (state_reg == ST_SCAN) && at_last && free_found_reg)
        else $error("slot claimed outside the end of a walk");

    // The reserved slot 0 is never part of a walk.
    a_no_slot_zero: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.rd_en |-> (rd_addr != '0) && (rd_addr <= LAST_SLOT))
        else $error("table read outside slots 1 to last");

    // A known or new address is never zero.
    a_addr_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_status == STAT_KNOWN || m_status == STAT_NEW))
        |-> (m_addr != 8'd0))
        else $error("assigned address is zero");

    // A walk ends with a result, never straight back to idle.
    a_walk_ends_resp: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |=> (state_reg == ST_SCAN || state_reg == ST_RESP))
        else $error("walk left without a result");

endmodule

// ===== hdl/uid_address_assigner_unit.sv =====
// ============================================================================
// uid_address_assigner_unit
// Node address assigner: looks up a 32-bit unique id in the slot table and
// returns its address, or claims the lowest free slot for a new id; a clear empties the table.
// ============================================================================
// A join reads the table once per slot from 1 to TABLE_SLOTS-1, ending early
// on a hit, then loads the result register; a clear goes straight to the
// result register. Only one request is handled at a time; the slot walk over
// the id memory's single read port sets the rate. Reset clears all used flags
// at once, so the table is empty and a request can be taken as soon as reset
// is released.
module uid_address_assigner_unit #(
    parameter int TABLE_SLOTS = 256
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] unique_id
    input  logic        s_tuser,   // [0] func (0 join, 1 clear)
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [7:0] node_address, [39:8] echoed_id
    output logic [1:0]  m_tuser    // [1:0] status
);
    import uaa_pkg::*;

    // Address width of the slot table.
    localparam int AW = $clog2(TABLE_SLOTS);

    tbl_cmd_t      cmd;
    logic [AW-1:0] rd_addr;
    logic [AW-1:0] wr_addr;
    logic [31:0]   wr_data;
    logic [31:0]   rd_data;
    logic          rd_used;
    logic [7:0]    node_address;
    logic [31:0]   echoed_id;

    // The controller walks the table, decides hit, claim or full, and owns
    // the result register that decouples the result beat from new requests.
    uaa_scan_ctrl #(
        .TABLE_SLOTS (TABLE_SLOTS),
        .AW          (AW)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_func   (s_tuser),
        .s_id     (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_status (m_tuser),
        .m_addr   (node_address),
        .m_id     (echoed_id),
        .cmd      (cmd),
        .rd_addr  (rd_addr),
        .wr_addr  (wr_addr),
        .wr_data  (wr_data),
        .rd_data  (rd_data),
        .rd_used  (rd_used)
    );

    // The table keeps the ids in memory and the used flags in flip-flops.
    uaa_id_table #(
        .TABLE_SLOTS (TABLE_SLOTS),
        .AW          (AW)
    ) u_table (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd),
        .rd_addr (rd_addr),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_data (rd_data),
        .rd_used (rd_used)
    );

    // Result beat: address in the low byte, echoed id above it.
    assign m_tdata = {echoed_id, node_address};

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 100ps
// ============================================================================
// tb_top
// Self-checking bench for the node address assigner. A scoreboard class keeps
// its own copy of the slot table, predicts the answer to every accepted
// request beat and compares each result beat field by field, in order.
// Stimulus is a short directed opening followed by random join sessions. Each
// session ends with a clear, and some sessions fill the table to the top.
// ============================================================================
module tb_top;

    import uaa_pkg::*;

    localparam int SLOTS       = 256;
    localparam int TOTAL_ITEMS = 1750;
    localparam int QUIET_TAIL  = 150;   // last beats run with no idling
    localparam int STALL_LIMIT = 4000;  // cycles with no beat on either side
    localparam int MAX_REPORTS = 100;

    // Request kinds carried on s_tuser.
    localparam bit OP_JOIN  = 1'b0;
    localparam bit OP_CLEAR = 1'b1;

    typedef struct packed {
        status_t     status;
        logic [7:0]  addr;
        logic [31:0] uid;
    } grant_t;

    // ------------------------------------------------------------------------
    // Scoreboard: a private copy of the slot table and the queue of answers
    // still owed by the block.
    // ------------------------------------------------------------------------
    class addr_table_scoreboard;
        bit          taken[SLOTS];
        logic [31:0] owner[SLOTS];
        grant_t      owed[$];
        int          mismatches;
        int          known_cnt;
        int          new_cnt;
        int          full_cnt;
        int          clear_cnt;

        function int pending();
            return owed.size();
        endfunction

        // Works out the answer to one accepted request and updates the table.
        function void note_request(bit op, logic [31:0] uid);
            grant_t want;
            int     hit;
            int     slot;
            want.uid = uid;
            want.addr = 8'd0;
            if (op == OP_CLEAR) begin
                // Used flags drop, stored ids stay behind but are dead.
                foreach (taken[i])
                    taken[i] = 1'b0;
                want.status = STAT_CLEARED;
            end else begin
                hit = 0;
                for (int i = 1; i < SLOTS && hit == 0; i++)
                    if (taken[i] && owner[i] == uid)
                        hit = i;
                if (hit != 0) begin
                    want.status = STAT_KNOWN;
                    want.addr = hit[7:0];
                end else begin
                    // The top slot is never handed out.
                    slot = 0;
                    for (int i = 1; i < SLOTS - 1 && slot == 0; i++)
                        if (!taken[i])
                            slot = i;
                    if (slot != 0) begin
                        taken[slot] = 1'b1;
                        owner[slot] = uid;
                        want.status = STAT_NEW;
                        want.addr = slot[7:0];
                    end else begin
                        want.status = STAT_FULL;
                    end
                end
            end
            owed.push_back(want);
        endfunction

        task report(string what);
            if (mismatches < MAX_REPORTS)
                $display("[%0t] MISMATCH %s", $time, what);
            mismatches++;
        endtask

        task check_result(grant_t got);
            grant_t want;
            if (owed.size() == 0) begin
                report($sformatf("result beat with no request pending: status %0d addr %0d id %08h",
                                 got.status, got.addr, got.uid));
            end else begin
                want = owed.pop_front();
                if (got.status !== want.status)
                    report($sformatf("status %0d, wanted %0d (id %08h)",
                                     got.status, want.status, want.uid));
                if (got.addr !== want.addr)
                    report($sformatf("node_address %0d, wanted %0d (id %08h)",
                                     got.addr, want.addr, want.uid));
                if (got.uid !== want.uid)
                    report($sformatf("echoed_id %08h, wanted %08h", got.uid, want.uid));
                case (want.status)
                    STAT_KNOWN:   known_cnt++;
                    STAT_NEW:     new_cnt++;
                    STAT_FULL:    full_cnt++;
                    STAT_CLEARED: clear_cnt++;
                    default:      ;
                endcase
            end
        endtask
    endclass

    // ------------------------------------------------------------------------
    // Clock, reset and the block
    // ------------------------------------------------------------------------
    logic        clk = 1'b0;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;
    logic        s_tuser;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;
    logic [1:0]  m_tuser;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    uid_address_assigner_unit #(
        .TABLE_SLOTS(SLOTS)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    addr_table_scoreboard sb = new();

    int          sent;
    int          fills;
    bit          quiet;
    int          rdy_hold;
    int          stall_cycles;
    logic [31:0] retired_ids[$];   // ids that were live before some clear

    // ------------------------------------------------------------------------
    // Result side: random back-pressure bursts, none in the quiet tail.
    // ------------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (rdy_hold != 0) begin
            rdy_hold <= rdy_hold - 1;
            m_tready <= 1'b0;
        end else if (!quiet && $urandom_range(0, 4) == 0) begin
            rdy_hold <= $urandom_range(1, 4) - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            sb.check_result({status_t'(m_tuser), m_tdata[7:0], m_tdata[39:8]});
    end

    // Watchdog: a join walks at most one slot per cycle, so a long stretch
    // with no beat on either side means the block has hung.
    always @(posedge clk)
    begin
        if (rst_n) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                stall_cycles <= 0;
            end else if (stall_cycles >= STALL_LIMIT) begin
                $display("[%0t] no beat for %0d cycles, giving up", $time, stall_cycles);
                $display("end of test: mismatches");
                $finish;
            end else begin
                stall_cycles <= stall_cycles + 1;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Request side
    // ------------------------------------------------------------------------

    // Presents one request beat, optionally after an idle burst, and waits
    // until it is taken. Valid stays high on return so back-to-back beats
    // need no extra edge.
    task send_beat(input bit op, input logic [31:0] uid);
        int gap;
        if (!quiet && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 4);
            repeat (gap) begin
                @(negedge clk);
                s_tvalid <= 1'b0;
            end
        end
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tdata  <= uid;
        s_tuser  <= op;
        do
            @(posedge clk);
        while (!s_tready);
        sb.note_request(op, uid);
        sent++;
        quiet = (sent >= TOTAL_ITEMS - QUIET_TAIL);
    endtask

    // One join session: fresh ids, repeats of live ids, near misses of live
    // ids and ids that died in an earlier clear, closed by a clear. A filling
    // session pushes past the last free slot and keeps asking afterwards.
    task automatic run_session(input bit fill_up);
        logic [31:0] live[$];
        logic [31:0] uid;
        int          target;
        int          fresh;
        int          pick;
        target = fill_up ? SLOTS + $urandom_range(2, 12) : $urandom_range(1, 40);
        fresh = 0;
        if (fill_up)
            fills++;
        while (fresh < target && sent < TOTAL_ITEMS) begin
            pick = $urandom_range(0, 99);
            if (pick < 3 && !fill_up) begin
                // Stray clear in the middle of a session.
                send_beat(OP_CLEAR, $urandom());
                foreach (live[i])
                    retired_ids.push_back(live[i]);
                live.delete();
            end else begin
                if (pick < 8 && retired_ids.size() != 0) begin
                    uid = retired_ids[$urandom_range(0, retired_ids.size() - 1)];
                end else if (pick < 14 && live.size() != 0) begin
                    uid = live[$urandom_range(0, live.size() - 1)] ^ (32'd1 << $urandom_range(0, 31));
                end else if (pick < 45 && live.size() != 0) begin
                    uid = live[$urandom_range(0, live.size() - 1)];
                end else begin
                    uid = $urandom();
                    live.push_back(uid);
                    fresh++;
                end
                send_beat(OP_JOIN, uid);
            end
        end
        send_beat(OP_CLEAR, $urandom());
        foreach (live[i])
            retired_ids.push_back(live[i]);
        while (retired_ids.size() > 64)
            void'(retired_ids.pop_front());
    endtask

    initial
    begin
        s_tvalid = 1'b0;
        s_tdata  = 32'd0;
        s_tuser  = OP_JOIN;
        rst_n    = 1'b0;
        sent     = 0;
        fills    = 0;
        quiet    = 1'b0;
        rdy_hold = 0;
        stall_cycles = 0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed opening: extreme ids, hits on the first two slots, a clear
        // whose ignored id must still be echoed, stale ids after a clear that
        // must not match, and a clear of an already empty table.
        send_beat(OP_JOIN,  32'h0000_0000);
        send_beat(OP_JOIN,  32'hFFFF_FFFF);
        send_beat(OP_JOIN,  32'h0000_0000);
        send_beat(OP_JOIN,  32'hFFFF_FFFF);
        send_beat(OP_JOIN,  32'h8000_0001);
        send_beat(OP_JOIN,  32'h7FFF_FFFE);
        send_beat(OP_JOIN,  32'hA5A5_A5A5);
        send_beat(OP_JOIN,  32'h5A5A_5A5A);
        send_beat(OP_JOIN,  32'h7FFF_FFFE);
        send_beat(OP_JOIN,  32'h8000_0000);
        send_beat(OP_CLEAR, 32'hDEAD_BEEF);
        send_beat(OP_JOIN,  32'hFFFF_FFFF);
        send_beat(OP_JOIN,  32'h8000_0001);
        send_beat(OP_JOIN,  32'hFFFF_FFFF);
        send_beat(OP_CLEAR, 32'h0000_0000);
        send_beat(OP_CLEAR, 32'hFFFF_FFFF);
        send_beat(OP_JOIN,  32'h5A5A_5A5A);
        send_beat(OP_CLEAR, 32'h1234_5678);

        // Random sessions; the first one always runs the table full.
        run_session(1'b1);
        while (sent < TOTAL_ITEMS)
            run_session($urandom_range(0, 9) == 0);

        @(negedge clk);
        s_tvalid <= 1'b0;

        while (sb.pending() != 0)
            @(posedge clk);
        // Anything that shows up now is a stray result.
        repeat (SLOTS + 8) @(posedge clk);
        if (sb.pending() != 0)
            sb.report($sformatf("%0d results never arrived", sb.pending()));

        $display("Ran %0d request beats: %0d hits, %0d new addresses, %0d table-full answers,",
                 sent, sb.known_cnt, sb.new_cnt, sb.full_cnt);
        $display("%0d clears, with the table filled to the top in %0d sessions.",
                 sb.clear_cnt, fills);
        if (sb.mismatches == 0) begin
            $display("end of test: clean");
        end else begin
            $display("%0d mismatches found", sb.mismatches);
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
hdl/uaa_pkg.sv
hdl/uaa_id_table.sv
hdl/uaa_scan_ctrl.sv
hdl/uid_address_assigner_unit.sv
bench/tb_top.sv
